### design/assert_macros.svh
// Assertion macros shared by the executor RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### design/mips_pkg.sv
// Shared types and constants for the MIPS32 instruction executor.
// Depends on nothing; used by mips_be, the top module and the testbench.
package mips_pkg;
	localparam int unsigned DmemWords = 1024;
	localparam logic [31:0] StartPcReset = 32'h0040_0000;
	localparam logic [31:0] ExitCode = 32'h0000_000A;
	localparam logic [4:0] LinkReg = 5'd31;

	// Back-end states, one-hot.
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_EXEC  = 6'b001000,
		ST_MDU   = 6'b010000,
		ST_OUT   = 6'b100000
	} be_state_t;

	// Result word handed to the output register.
	typedef struct packed {
		logic [31:0] next_pc;
		logic        dest_written;
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		logic        store_done;
		logic        halted;
	} result_t;
endpackage

### design/mips_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module mips_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read during a write returns the old contents; read data registered.
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

### design/mips_fq.sv
// Front end: accepts instruction words into a two-entry queue.
// Depends on nothing; stands alone.
module mips_fq (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_word,
	output logic        q_valid,
	input  logic        q_pop,
	output logic [31:0] q_word
);
	logic [31:0] ent_q [2];
	logic        rd_q, wr_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_word = ent_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= in_word;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### design/mips_div.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// Depends on nothing.
module mips_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quot,
	output logic [31:0] rem
);
	logic [31:0] q_q, r_q, d_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;

	assign busy = (cnt_q != 6'd0);
	assign quot = q_q;
	assign rem = r_q;
	assign trial = {r_q, q_q[31]} - {1'b0, d_q};

	// Counter control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 6'd0;
		else if (start)
			cnt_q <= 6'd32;
		else if (busy)
			cnt_q <= cnt_q - 6'd1;
	end

	// One shift-subtract step per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= 32'd0;
			d_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= {r_q[30:0], q_q[31]};
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end
endmodule

### design/mips_be.sv
// Back end: register file, HI/LO, data memory, execution and result.
// Depends on mips_pkg, mips_ram, mips_div and assert_macros.svh.
`include "assert_macros.svh"
module mips_be #(
	parameter int unsigned DMEM_WORDS = mips_pkg::DmemWords
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [31:0]          cfg_data,
	output logic                 cfg_ready,
	input  logic                 q_valid,
	input  logic [31:0]          q_word,
	output logic                 q_pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output mips_pkg::result_t    res
);
	localparam int unsigned AW = $clog2(DMEM_WORDS);

	mips_pkg::be_state_t st_q;
	logic [31:0] pc_q, hi_q, lo_q;
	logic [31:0] gpr_q [32];
	logic        stop_q;
	logic [AW-1:0] clr_q;
	logic [31:0] ins_q, a_q, b_q;
	logic [2:0]  mdu_q;
	logic        mul_q;
	logic [63:0] prod_q;
	mips_pkg::result_t res_q;
	logic        neg_a_q, neg_b_q;

	// Instruction fields.
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [31:0] simm, zimm, pc4, br, jt, addr, addr_rd;
	assign op = ins_q[31:26];
	assign rs = ins_q[25:21];
	assign rt = ins_q[20:16];
	assign rd = ins_q[15:11];
	assign sa = ins_q[10:6];
	assign fn = ins_q[5:0];
	assign simm = {{16{ins_q[15]}}, ins_q[15:0]};
	assign zimm = {16'd0, ins_q[15:0]};
	assign pc4 = pc_q + 32'd4;
	assign br = pc4 + {simm[29:0], 2'b00};
	assign jt = {pc4[31:28], ins_q[25:0], 2'b00};
	assign addr = a_q + simm;
	// Address formed from the register file while operands are read, so that
	// the memory word is ready in the execute cycle.
	assign addr_rd = gpr_q[rs] + simm;

	// Data memory.
	logic          m_we;
	logic [AW-1:0] m_addr;
	logic [31:0]   m_wdata, m_rdata;
	mips_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
	);

	// Divider on magnitudes.
	logic        dv_start, dv_busy;
	logic [31:0] dv_q, dv_r, dv_a, dv_b;
	mips_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
		.busy(dv_busy), .quot(dv_q), .rem(dv_r)
	);

	logic is_r, is_div, is_mul, is_sgn;
	assign is_r = (op == 6'h00);
	assign is_div = is_r && (fn == 6'h1A || fn == 6'h1B) && (b_q != 32'd0);
	assign is_mul = is_r && (fn == 6'h18 || fn == 6'h19);
	assign is_sgn = (fn == 6'h1A) || (fn == 6'h18);
	assign dv_a = (is_sgn && a_q[31]) ? 32'd0 - a_q : a_q;
	assign dv_b = (is_sgn && b_q[31]) ? 32'd0 - b_q : b_q;
	assign dv_start = (st_q == mips_pkg::ST_EXEC) && is_div && !stop_q;

	// Multiplier on 33-bit operands, sign bit set only for the signed form.
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_w;
	assign mul_a = {is_sgn && a_q[31], a_q};
	assign mul_b = {is_sgn && b_q[31], b_q};
	assign prod_w = mul_a * mul_b;

	// Byte and half lanes of the loaded word.
	logic [7:0]  ld_b;
	logic [15:0] ld_h;
	assign ld_b = m_rdata[{addr[1:0], 3'b000} +: 8];
	assign ld_h = m_rdata[{addr[1], 4'b0000} +: 16];

	// Store merge and memory port select.
	always_comb begin
		m_we = 1'b0;
		m_addr = addr[AW+1:2];
		m_wdata = b_q;
		if (st_q == mips_pkg::ST_CLEAR) begin
			m_we = 1'b1;
			m_addr = clr_q;
			m_wdata = 32'd0;
		end else if (st_q == mips_pkg::ST_READ) begin
			m_addr = addr_rd[AW+1:2];
		end else if (st_q == mips_pkg::ST_EXEC && !stop_q) begin
			unique case (op)
				6'h28: begin
					m_we = 1'b1;
					m_wdata = m_rdata;
					m_wdata[{addr[1:0], 3'b000} +: 8] = b_q[7:0];
				end
				6'h29: begin
					m_we = 1'b1;
					m_wdata = m_rdata;
					m_wdata[{addr[1], 4'b0000} +: 16] = b_q[15:0];
				end
				6'h2B: m_we = 1'b1;
				default: m_we = 1'b0;
			endcase
		end
	end

	// Execute one instruction from registered operands.
	logic        wr, stw, halt_now;
	logic [4:0]  widx;
	logic [31:0] wv, npc;
	logic [31:0] sra_v, srav_v;
	assign sra_v = $signed(b_q) >>> sa;
	assign srav_v = $signed(b_q) >>> a_q[4:0];
	always_comb begin
		wr = 1'b0; widx = 5'd0; wv = 32'd0; npc = pc4; stw = 1'b0; halt_now = 1'b0;
		unique case (op)
			6'h00: begin
				unique case (fn)
					6'h00: begin wr = 1'b1; widx = rd; wv = b_q << sa; end
					6'h02: begin wr = 1'b1; widx = rd; wv = b_q >> sa; end
					6'h03: begin wr = 1'b1; widx = rd; wv = sra_v; end
					6'h04: begin wr = 1'b1; widx = rd; wv = b_q << a_q[4:0]; end
					6'h06: begin wr = 1'b1; widx = rd; wv = b_q >> a_q[4:0]; end
					6'h07: begin wr = 1'b1; widx = rd; wv = srav_v; end
					6'h08: npc = a_q;
					6'h09: begin wr = 1'b1; widx = rd; wv = pc4; npc = a_q; end
					6'h0C: halt_now = (gpr_q[2] == mips_pkg::ExitCode);
					6'h10: begin wr = 1'b1; widx = rd; wv = hi_q; end
					6'h12: begin wr = 1'b1; widx = rd; wv = lo_q; end
					6'h20, 6'h21: begin wr = 1'b1; widx = rd; wv = a_q + b_q; end
					6'h22, 6'h23: begin wr = 1'b1; widx = rd; wv = a_q - b_q; end
					6'h24: begin wr = 1'b1; widx = rd; wv = a_q & b_q; end
					6'h25: begin wr = 1'b1; widx = rd; wv = a_q | b_q; end
					6'h26: begin wr = 1'b1; widx = rd; wv = a_q ^ b_q; end
					6'h27: begin wr = 1'b1; widx = rd; wv = ~(a_q | b_q); end
					6'h2A: begin
						wr = 1'b1; widx = rd;
						wv = {31'd0, $signed(a_q) < $signed(b_q)};
					end
					6'h2B: begin wr = 1'b1; widx = rd; wv = {31'd0, a_q < b_q}; end
					default: wr = 1'b0;
				endcase
			end
			6'h01: begin
				unique case (rt)
					5'h00: npc = a_q[31] ? br : pc4;
					5'h01: npc = a_q[31] ? pc4 : br;
					5'h10: begin
						npc = a_q[31] ? br : pc4;
						wr = 1'b1; widx = mips_pkg::LinkReg; wv = pc4;
					end
					5'h11: begin
						npc = a_q[31] ? pc4 : br;
						wr = 1'b1; widx = mips_pkg::LinkReg; wv = pc4;
					end
					default: npc = pc4;
				endcase
			end
			6'h02: npc = jt;
			6'h03: begin npc = jt; wr = 1'b1; widx = mips_pkg::LinkReg; wv = pc4; end
			6'h04: npc = (a_q == b_q) ? br : pc4;
			6'h05: npc = (a_q != b_q) ? br : pc4;
			6'h06: npc = (a_q == 32'd0 || a_q[31]) ? br : pc4;
			6'h07: npc = (a_q != 32'd0 && !a_q[31]) ? br : pc4;
			6'h08, 6'h09: begin wr = 1'b1; widx = rt; wv = addr; end
			6'h0A: begin
				wr = 1'b1; widx = rt; wv = {31'd0, $signed(a_q) < $signed(simm)};
			end
			6'h0B: begin wr = 1'b1; widx = rt; wv = {31'd0, a_q < simm}; end
			6'h0C: begin wr = 1'b1; widx = rt; wv = a_q & zimm; end
			6'h0D: begin wr = 1'b1; widx = rt; wv = a_q | zimm; end
			6'h0E: begin wr = 1'b1; widx = rt; wv = a_q ^ zimm; end
			6'h0F: begin wr = 1'b1; widx = rt; wv = {ins_q[15:0], 16'd0}; end
			6'h20: begin wr = 1'b1; widx = rt; wv = {{24{ld_b[7]}}, ld_b}; end
			6'h21: begin wr = 1'b1; widx = rt; wv = {{16{ld_h[15]}}, ld_h}; end
			6'h23: begin wr = 1'b1; widx = rt; wv = m_rdata; end
			6'h24: begin wr = 1'b1; widx = rt; wv = {24'd0, ld_b}; end
			6'h25: begin wr = 1'b1; widx = rt; wv = {16'd0, ld_h}; end
			6'h28, 6'h29, 6'h2B: stw = 1'b1;
			default: wr = 1'b0;
		endcase
		if (widx == 5'd0) begin
			wr = 1'b0; wv = 32'd0;
		end
		if (!wr) begin
			widx = 5'd0; wv = 32'd0;
		end
	end

	assign q_pop = (st_q == mips_pkg::ST_IDLE) && q_valid;
	assign cfg_ready = (st_q == mips_pkg::ST_IDLE) && !q_valid;
	assign res_valid = (st_q == mips_pkg::ST_OUT);
	assign res = res_q;

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mips_pkg::ST_CLEAR;
			clr_q <= '0;
			pc_q <= mips_pkg::StartPcReset;
			hi_q <= 32'd0;
			lo_q <= 32'd0;
			stop_q <= 1'b0;
			mdu_q <= 3'd0;
			res_q <= '0;
			mul_q <= 1'b0;
			neg_a_q <= 1'b0;
			neg_b_q <= 1'b0;
			for (int i = 0; i < 32; i++)
				gpr_q[i] <= 32'd0;
		end else begin
			unique case (st_q)
				mips_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DMEM_WORDS - 1))
						st_q <= mips_pkg::ST_IDLE;
				end
				mips_pkg::ST_IDLE: begin
					if (cfg_valid && cfg_ready)
						pc_q <= cfg_data;
					if (q_valid)
						st_q <= mips_pkg::ST_READ;
				end
				mips_pkg::ST_READ: st_q <= mips_pkg::ST_EXEC;
				mips_pkg::ST_EXEC: begin
					if (stop_q) begin
						res_q <= '{pc_q, 1'b0, 5'd0, 32'd0, 1'b0, 1'b1};
						st_q <= mips_pkg::ST_OUT;
					end else begin
						if (wr)
							gpr_q[widx] <= wv;
						pc_q <= npc;
						if (halt_now)
							stop_q <= 1'b1;
						if (is_r && fn == 6'h11)
							hi_q <= a_q;
						if (is_r && fn == 6'h13)
							lo_q <= a_q;
						res_q <= '{npc, wr, widx, wv, stw, halt_now};
						mul_q <= is_mul;
						neg_a_q <= is_sgn && a_q[31];
						neg_b_q <= is_sgn && b_q[31];
						mdu_q <= 3'd1;
						st_q <= (is_div || is_mul) ? mips_pkg::ST_MDU : mips_pkg::ST_OUT;
					end
				end
				mips_pkg::ST_MDU: begin
					if (mul_q) begin
						if (mdu_q == 3'd1)
							mdu_q <= 3'd2;
						else begin
							hi_q <= prod_q[63:32];
							lo_q <= prod_q[31:0];
							st_q <= mips_pkg::ST_OUT;
						end
					end else if (!dv_busy) begin
						lo_q <= (neg_a_q != neg_b_q) ? 32'd0 - dv_q : dv_q;
						hi_q <= neg_a_q ? 32'd0 - dv_r : dv_r;
						st_q <= mips_pkg::ST_OUT;
					end
				end
				mips_pkg::ST_OUT: begin
					if (res_ready)
						st_q <= mips_pkg::ST_IDLE;
				end
				default: st_q <= mips_pkg::ST_IDLE;
			endcase
		end
	end

	// Operand capture and multiplier register.
	always_ff @(posedge clk) begin
		if (q_pop)
			ins_q <= q_word;
		if (st_q == mips_pkg::ST_READ) begin
			a_q <= gpr_q[rs];
			b_q <= gpr_q[rt];
		end
		if (st_q == mips_pkg::ST_EXEC)
			prod_q <= prod_w[63:0];
	end

	`ASSERT_IMP(a_r0_zero, clk, arst_n, 1'b1, gpr_q[0] == 32'd0)
	`ASSERT_IMP(a_no_pop_busy, clk, arst_n, q_pop, st_q == mips_pkg::ST_IDLE)
	`ASSERT_NEXT(a_stop_sticky, clk, arst_n, stop_q, stop_q)
	`ASSERT_IMP(a_res_idx, clk, arst_n, res_valid && !res_q.dest_written,
		res_q.dest_index == 5'd0)
endmodule

### design/mips32_instruction_executor_top.sv
// MIPS32 instruction executor: one instruction word in, one result word out.
// Channels: in (instruction), out (result fields), cfg (start_pc write).
// Each word is queued by the front end (two entries) and executed by the
// back end sequencer: read operands, execute, present result.
// Multiply and divide add an MDU state before the result: multiply
// registers the product, then writes HI/LO; divide runs the divider (one
// quotient bit per cycle), then writes HI/LO. The queue can take words while
// the back end is busy, but the sequencer works on one instruction at a
// time since each depends on the state left before.
// Reset clears registers and starts a clearing pass that zeroes every data
// memory word; no word is executed during it. A cfg write loads start_pc
// into the PC and is taken when the back end is idle and queue empty.
// When the receiver stalls, the result holds and the queue fills, then
// in_ready drops. After exit syscall, words still yield a halted result.
// Depends on mips_pkg, mips_fq, mips_be.
module mips32_instruction_executor_top #(
	parameter int unsigned DMEM_WORDS = mips_pkg::DmemWords
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] start_pc,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] next_pc,
	output logic        dest_written,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic        store_done,
	output logic        halted
);
	logic        q_valid, q_pop;
	logic [31:0] q_word;
	mips_pkg::result_t res;

	mips_fq u_fq (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_word(instruction), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
	);

	mips_be #(.DMEM_WORDS(DMEM_WORDS)) u_be (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_data(start_pc),
		.cfg_ready(cfg_ready), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
		.res_valid(out_valid), .res_ready(out_ready), .res(res)
	);

	assign next_pc = res.next_pc;
	assign dest_written = res.dest_written;
	assign dest_index = res.dest_index;
	assign dest_value = res.dest_value;
	assign store_done = res.store_done;
	assign halted = res.halted;
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the MIPS32 instruction executor.
// Depends on mips_pkg and mips32_instruction_executor_top; a built-in
// predictor of the architectural state checks every result word.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Major opcodes.
	localparam logic [5:0] OP_SPECIAL = 6'h00, OP_REGIMM = 6'h01, OP_J = 6'h02,
		OP_JAL = 6'h03, OP_BEQ = 6'h04, OP_BNE = 6'h05, OP_BLEZ = 6'h06,
		OP_BGTZ = 6'h07, OP_ADDI = 6'h08, OP_ADD_IMM_U = 6'h09, OP_SLTI = 6'h0A,
		OP_SLT_IMM_U = 6'h0B, OP_ANDI = 6'h0C, OP_ORI = 6'h0D, OP_XORI = 6'h0E,
		OP_LUI = 6'h0F, OP_LB = 6'h20, OP_LH = 6'h21, OP_LW = 6'h23,
		OP_LBU = 6'h24, OP_LHU = 6'h25, OP_SB = 6'h28, OP_SH = 6'h29,
		OP_SW = 6'h2B;
	// Function codes of the SPECIAL group.
	localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03,
		FN_SLLV = 6'h04, FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08,
		FN_JALR = 6'h09, FN_SYSCALL = 6'h0C, FN_MFHI = 6'h10, FN_MTHI = 6'h11,
		FN_MFLO = 6'h12, FN_MTLO = 6'h13, FN_MULT = 6'h18, FN_MULTU = 6'h19,
		FN_DIV = 6'h1A, FN_DIVU = 6'h1B, FN_ADD = 6'h20, FN_ADDU = 6'h21,
		FN_SUB = 6'h22, FN_SUBU = 6'h23, FN_AND = 6'h24, FN_OR = 6'h25,
		FN_XOR = 6'h26, FN_NOR = 6'h27, FN_SLT = 6'h2A, FN_SLTU = 6'h2B;
	// REGIMM selectors.
	localparam logic [4:0] RI_BLTZ = 5'h00, RI_BGEZ = 5'h01, RI_BLTZAL = 5'h10,
		RI_BGEZAL = 5'h11;

	// One row of the directed table.
	typedef struct {
		logic [31:0]       ins;
		bit                known;
		mips_pkg::result_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] start_pc = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] instruction = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] next_pc;
	logic        dest_written;
	logic [4:0]  dest_index;
	logic [31:0] dest_value;
	logic        store_done;
	logic        halted;

	mips32_instruction_executor_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .start_pc(start_pc),
		.in_valid(in_valid), .in_ready(in_ready), .instruction(instruction),
		.out_valid(out_valid), .out_ready(out_ready), .next_pc(next_pc),
		.dest_written(dest_written), .dest_index(dest_index),
		.dest_value(dest_value), .store_done(store_done), .halted(halted)
	);

	always #1 clk = ~clk;

	// Predicted architectural state.
	logic [31:0] arch_pc;
	logic [31:0] gpr [32];
	logic [31:0] hi_reg, lo_reg;
	logic [31:0] dmem [mips_pkg::DmemWords];
	logic        core_stopped;

	mips_pkg::result_t pending_results [$];
	int          errors = 0;
	bit          stall_hold = 1'b0;

	function automatic logic [31:0] sext16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	task automatic predict_reset();
		arch_pc = mips_pkg::StartPcReset;
		for (int i = 0; i < 32; i++) gpr[i] = '0;
		hi_reg = '0;
		lo_reg = '0;
		for (int i = 0; i < mips_pkg::DmemWords; i++) dmem[i] = '0;
		core_stopped = 1'b0;
	endtask

	// Executes one instruction on the predicted state and returns its result.
	function automatic mips_pkg::result_t execute_instr(logic [31:0] ins);
		mips_pkg::result_t res;
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sa, widx;
		logic [31:0] a, b, pc4, npc, addr, simm, zimm, wv, q, r, ma, mb;
		logic [63:0] prod;
		int unsigned slot, lane;
		bit          wr, st, take;
		op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
		sa = ins[10:6]; fn = ins[5:0];
		simm = sext16(ins[15:0]);
		zimm = {16'h0, ins[15:0]};
		res = '0;
		if (core_stopped) begin
			res.next_pc = arch_pc;
			res.halted = 1'b1;
			return res;
		end
		a = gpr[rs]; b = gpr[rt];
		pc4 = arch_pc + 32'd4;
		npc = pc4;
		addr = a + simm;
		slot = (addr >> 2) % mips_pkg::DmemWords;
		wr = 0; st = 0; take = 0; widx = '0; wv = '0;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_SLL: begin wr = 1; widx = rd; wv = b << sa; end
					FN_SRL: begin wr = 1; widx = rd; wv = b >> sa; end
					FN_SRA: begin wr = 1; widx = rd; wv = $signed(b) >>> sa; end
					FN_SLLV: begin wr = 1; widx = rd; wv = b << a[4:0]; end
					FN_SRLV: begin wr = 1; widx = rd; wv = b >> a[4:0]; end
					FN_SRAV: begin wr = 1; widx = rd; wv = $signed(b) >>> a[4:0]; end
					FN_JR: npc = a;
					FN_JALR: begin wr = 1; widx = rd; wv = pc4; npc = a; end
					FN_SYSCALL: if (gpr[2] == mips_pkg::ExitCode) core_stopped = 1'b1;
					FN_MFHI: begin wr = 1; widx = rd; wv = hi_reg; end
					FN_MTHI: hi_reg = a;
					FN_MFLO: begin wr = 1; widx = rd; wv = lo_reg; end
					FN_MTLO: lo_reg = a;
					FN_MULT: begin
						prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
						{hi_reg, lo_reg} = prod;
					end
					FN_MULTU: begin
						prod = {32'h0, a} * {32'h0, b};
						{hi_reg, lo_reg} = prod;
					end
					FN_DIV: if (b != 0) begin
						ma = a[31] ? -a : a;
						mb = b[31] ? -b : b;
						q = ma / mb;
						r = ma % mb;
						lo_reg = (a[31] != b[31]) ? -q : q;
						hi_reg = a[31] ? -r : r;
					end
					FN_DIVU: if (b != 0) begin
						lo_reg = a / b;
						hi_reg = a % b;
					end
					FN_ADD, FN_ADDU: begin wr = 1; widx = rd; wv = a + b; end
					FN_SUB, FN_SUBU: begin wr = 1; widx = rd; wv = a - b; end
					FN_AND: begin wr = 1; widx = rd; wv = a & b; end
					FN_OR: begin wr = 1; widx = rd; wv = a | b; end
					FN_XOR: begin wr = 1; widx = rd; wv = a ^ b; end
					FN_NOR: begin wr = 1; widx = rd; wv = ~(a | b); end
					FN_SLT: begin
						wr = 1; widx = rd; wv = {31'h0, $signed(a) < $signed(b)};
					end
					FN_SLTU: begin wr = 1; widx = rd; wv = {31'h0, a < b}; end
					default: ;
				endcase
			end
			OP_REGIMM: begin
				case (rt)
					RI_BLTZ: take = a[31];
					RI_BGEZ: take = !a[31];
					RI_BLTZAL: begin
						take = a[31]; wr = 1; widx = mips_pkg::LinkReg; wv = pc4;
					end
					RI_BGEZAL: begin
						take = !a[31]; wr = 1; widx = mips_pkg::LinkReg; wv = pc4;
					end
					default: ;
				endcase
				if (take) npc = pc4 + (simm << 2);
			end
			OP_J: npc = {pc4[31:28], ins[25:0], 2'b00};
			OP_JAL: begin
				wr = 1; widx = mips_pkg::LinkReg; wv = pc4;
				npc = {pc4[31:28], ins[25:0], 2'b00};
			end
			OP_BEQ: if (a == b) npc = pc4 + (simm << 2);
			OP_BNE: if (a != b) npc = pc4 + (simm << 2);
			OP_BLEZ: if (a == 0 || a[31]) npc = pc4 + (simm << 2);
			OP_BGTZ: if (a != 0 && !a[31]) npc = pc4 + (simm << 2);
			OP_ADDI, OP_ADD_IMM_U: begin wr = 1; widx = rt; wv = a + simm; end
			OP_SLTI: begin
				wr = 1; widx = rt; wv = {31'h0, $signed(a) < $signed(simm)};
			end
			OP_SLT_IMM_U: begin wr = 1; widx = rt; wv = {31'h0, a < simm}; end
			OP_ANDI: begin wr = 1; widx = rt; wv = a & zimm; end
			OP_ORI: begin wr = 1; widx = rt; wv = a | zimm; end
			OP_XORI: begin wr = 1; widx = rt; wv = a ^ zimm; end
			OP_LUI: begin wr = 1; widx = rt; wv = zimm << 16; end
			OP_LB: begin
				lane = addr[1:0] * 8;
				wr = 1; widx = rt; wv = dmem[slot] >> lane;
				wv = {{24{wv[7]}}, wv[7:0]};
			end
			OP_LH: begin
				lane = addr[1] * 16;
				wr = 1; widx = rt; wv = dmem[slot] >> lane;
				wv = sext16(wv[15:0]);
			end
			OP_LW: begin wr = 1; widx = rt; wv = dmem[slot]; end
			OP_LBU: begin
				lane = addr[1:0] * 8;
				wr = 1; widx = rt; wv = (dmem[slot] >> lane) & 32'hFF;
			end
			OP_LHU: begin
				lane = addr[1] * 16;
				wr = 1; widx = rt; wv = (dmem[slot] >> lane) & 32'hFFFF;
			end
			OP_SB: begin
				lane = addr[1:0] * 8;
				dmem[slot] = (dmem[slot] & ~(32'hFF << lane)) | ((b & 32'hFF) << lane);
				st = 1;
			end
			OP_SH: begin
				lane = addr[1] * 16;
				dmem[slot] = (dmem[slot] & ~(32'hFFFF << lane)) | ((b & 32'hFFFF) << lane);
				st = 1;
			end
			OP_SW: begin dmem[slot] = b; st = 1; end
			default: ;
		endcase
		if (wr && widx != 0) gpr[widx] = wv;
		else begin wr = 0; widx = '0; wv = '0; end
		arch_pc = npc;
		res.next_pc = npc;
		res.dest_written = wr;
		res.dest_index = widx;
		res.dest_value = wv;
		res.store_done = st;
		res.halted = core_stopped;
		return res;
	endfunction

	function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [4:0] sa, logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic row_t mk_row(logic [31:0] ins, bit known, mips_pkg::result_t want);
		row_t row;
		row.ins = ins;
		row.known = known;
		row.want = want;
		return row;
	endfunction

	// Sends one word; the predictor runs on the cycle of acceptance. Valid
	// stays high afterwards so that words can follow back to back.
	task automatic send_word(logic [31:0] ins);
		in_valid <= 1'b1;
		instruction <= ins;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(execute_instr(ins));
		@(negedge clk);
	endtask

	// Sends one word and also checks the predictor against a typed-in result.
	task automatic send_known(logic [31:0] ins, mips_pkg::result_t want);
		mips_pkg::result_t got;
		send_word(ins);
		got = pending_results[$];
		if (got !== want) begin
			$display("%0t: directed row mismatch for %h: expected %p actual %p",
				$time, ins, want, got);
			errors++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_start_pc(logic [31:0] v);
		cfg_valid <= 1'b1;
		start_pc <= v;
		do @(posedge clk); while (!cfg_ready);
		arch_pc = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random gap before a word, in bursts.
	int burst_left = 0;
	task automatic sender_gap();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	// Random instruction with bias toward low registers.
	function automatic logic [31:0] random_instr();
		logic [5:0] ops [] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM, OP_J,
			OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADD_IMM_U, OP_SLTI,
			OP_SLT_IMM_U, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU,
			OP_LHU, OP_SB, OP_SH, OP_SW, OP_SW, OP_LW};
		logic [5:0] fns [] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
			FN_JR, FN_JALR, FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
			FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND,
			FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
		logic [31:0] ins;
		logic [5:0]  fn;
		ins = $urandom();
		if ($urandom_range(0, 19) == 0) return ins;
		ins[31:26] = ops[$urandom_range(0, ops.size() - 1)];
		if ($urandom_range(0, 3) != 0) ins[25:21] = $urandom_range(0, 7);
		if ($urandom_range(0, 3) != 0) ins[20:16] = $urandom_range(0, 7);
		if (ins[31:26] == OP_SPECIAL) begin
			fn = fns[$urandom_range(0, fns.size() - 1)];
			// Exit syscall would stop the rest of the run; keep it rare.
			if (fn == FN_SYSCALL && $urandom_range(0, 9) != 0) fn = FN_ADDU;
			ins[5:0] = fn;
		end
		if (ins[31:26] == OP_REGIMM)
			ins[20:16] = $urandom_range(0, 4) == 0 ? 5'($urandom) :
				(($urandom_range(0, 1) ? RI_BLTZAL : RI_BLTZ) | 5'($urandom_range(0, 1)));
		return ins;
	endfunction

	initial begin
		row_t rows [$];
		mips_pkg::result_t none;
		none = '0;
		predict_reset();

		// Directed table: the reset value of start_pc first, then extremes.
		rows.push_back(mk_row(itype(OP_ADD_IMM_U, 5'd0, 5'd1, 16'h8000), 1'b1,
			'{32'h0040_0004, 1'b1, 5'd1, 32'hFFFF_8000, 1'b0, 1'b0}));
		rows.push_back(mk_row(itype(OP_LUI, 5'd0, 5'd2, 16'hFFFF), 1'b1,
			'{32'h0040_0008, 1'b1, 5'd2, 32'hFFFF_0000, 1'b0, 1'b0}));
		rows.push_back(mk_row(itype(OP_ORI, 5'd0, 5'd3, 16'hFFFF), 1'b1,
			'{32'h0040_000C, 1'b1, 5'd3, 32'h0000_FFFF, 1'b0, 1'b0}));
		rows.push_back(mk_row(itype(OP_ADD_IMM_U, 5'd3, 5'd0, 16'h0001), 1'b1,
			'{32'h0040_0010, 1'b0, 5'd0, 32'h0000_0000, 1'b0, 1'b0}));
		rows.push_back(mk_row(rtype(5'd2, 5'd1, 5'd4, 5'd0, FN_SLT), 1'b0, none));
		rows.push_back(mk_row(itype(OP_SLTI, 5'd2, 5'd5, 16'h8000), 1'b0, none));
		rows.push_back(mk_row(itype(OP_ADD_IMM_U, 5'd0, 5'd6, 16'h7FFF), 1'b0, none));
		rows.push_back(mk_row(itype(OP_SLT_IMM_U, 5'd1, 5'd7, 16'hFFFF), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd0, 5'd1, 5'd8, 5'd31, FN_SRA), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd1, 5'd1, 5'd9, 5'd0, FN_SRLV), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_MULT), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd0, 5'd0, 5'd10, 5'd0, FN_MFHI), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_DIV), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd0, 5'd0, 5'd11, 5'd0, FN_MFLO), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd2, 5'd1, 5'd0, 5'd0, FN_DIVU), 1'b0, none));
		rows.push_back(mk_row(itype(OP_LUI, 5'd0, 5'd15, 16'h8000), 1'b0, none));
		rows.push_back(mk_row(itype(OP_ADD_IMM_U, 5'd0, 5'd16, 16'hFFFF), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd15, 5'd16, 5'd0, 5'd0, FN_DIV), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd0, 5'd0, 5'd17, 5'd0, FN_MFLO), 1'b0, none));
		rows.push_back(mk_row(rtype(5'd0, 5'd0, 5'd18, 5'd0, FN_MFHI), 1'b0, none));
		rows.push_back(mk_row(itype(OP_SW, 5'd0, 5'd1, 16'hFFFC), 1'b0, none));
		rows.push_back(mk_row(itype(OP_SB, 5'd0, 5'd3, 16'h0001), 1'b0, none));
		rows.push_back(mk_row(itype(OP_SH, 5'd0, 5'd6, 16'h0006), 1'b0, none));
		rows.push_back(mk_row(itype(OP_LB, 5'd0, 5'd12, 16'h0001), 1'b0, none));
		rows.push_back(mk_row(itype(OP_LHU, 5'd0, 5'd13, 16'h0007), 1'b0, none));
		rows.push_back(mk_row(itype(OP_REGIMM, 5'd1, RI_BGEZAL, 16'h0004), 1'b0, none));
		rows.push_back(mk_row(itype(OP_REGIMM, 5'd1, RI_BLTZAL, 16'hFFFC), 1'b0, none));
		rows.push_back(mk_row({OP_JAL, 26'h3FF_FFFF}, 1'b0, none));
		rows.push_back(mk_row(rtype(5'd31, 5'd0, 5'd14, 5'd0, FN_JALR), 1'b0, none));

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].known) send_known(rows[i].ins, rows[i].want);
			else send_word(rows[i].ins);
		end
		drain();

		// Random phases across several start_pc settings.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_start_pc(32'h0000_0000);
				1: write_start_pc(32'hFFFF_FFFC);
				5: write_start_pc(mips_pkg::StartPcReset);
				default: write_start_pc($urandom & 32'hFFFF_FFFC);
			endcase
			for (int n = 0; n < 300; n++) begin
				sender_gap();
				send_word(random_instr());
				if (phase == 2 && n == 100) begin
					// Long receiver hold while words keep arriving.
					stall_hold = 1'b1;
					for (int k = 0; k < 6; k++) send_word(random_instr());
					stall_hold = 1'b0;
				end
				if (phase == 3 && n == 150) drain();
			end
			drain();
		end

		// Halt: set r2 to the exit code and issue the syscall, then words after it.
		send_word(itype(OP_ADD_IMM_U, 5'd0, 5'd2, 16'h000A));
		send_word(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
		for (int n = 0; n < 20; n++) send_word(random_instr());
		drain();
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	// Receiver stall pattern, plus a long hold counted here.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_hold) begin
				out_ready <= 1'b0;
				repeat (200) @(negedge clk);
			end
			case ($urandom_range(0, 3))
				0: out_ready <= 1'b0;
				default: out_ready <= 1'b1;
			endcase
		end
	end

	// Result checker.
	always @(posedge clk) begin
		mips_pkg::result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, next_pc %h", $time, next_pc);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (next_pc !== exp_r.next_pc) begin
					$display("%0t: next_pc expected %h actual %h", $time, exp_r.next_pc, next_pc);
					errors++;
				end
				if (dest_written !== exp_r.dest_written) begin
					$display("%0t: dest_written expected %b actual %b", $time,
						exp_r.dest_written, dest_written);
					errors++;
				end
				if (dest_index !== exp_r.dest_index) begin
					$display("%0t: dest_index expected %0d actual %0d", $time,
						exp_r.dest_index, dest_index);
					errors++;
				end
				if (dest_value !== exp_r.dest_value) begin
					$display("%0t: dest_value expected %h actual %h", $time,
						exp_r.dest_value, dest_value);
					errors++;
				end
				if (store_done !== exp_r.store_done) begin
					$display("%0t: store_done expected %b actual %b", $time,
						exp_r.store_done, store_done);
					errors++;
				end
				if (halted !== exp_r.halted) begin
					$display("%0t: halted expected %b actual %b", $time, exp_r.halted, halted);
					errors++;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

### mips32_instruction_executor_top.f
+incdir+design
design/mips_pkg.sv
design/mips_ram.sv
design/mips_fq.sv
design/mips_div.sv
design/mips_be.sv
design/mips32_instruction_executor_top.sv
tb/sv/testbench.sv
